@@ rtl/core/sma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants for the spectrum magnitude averager.
// ----------------------------------------------------------------------------
package sma_pkg;

  // default transform length, bins run 0 .. WINDOW_SIZE/2
  localparam int DEF_WINDOW_SIZE = 2048;

  // item kinds
  localparam logic [1:0] KIND_ACC   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // configuration space
  localparam int         CFG_ADDR_W     = 3;
  localparam logic       REG_ADD_GAIN   = 1'b0;
  localparam logic [31:0] ADD_GAIN_RESET = 32'h0001_0000;

  // iteration counts of the shared units
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 64;
  localparam int STEP_W     = 6;

  typedef struct packed {
    logic [1:0]         kind;
    logic [10:0]        bin_index;
    logic signed [31:0] real_part;
    logic signed [31:0] imag_part;
  } item_t;

  typedef struct packed {
    logic [63:0] average_value;
    logic [63:0] peak_value;
    logic [31:0] frames_seen;
  } result_t;

endpackage

@@ rtl/core/sma_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface sma_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/sma_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/spectrum_magnitude_averager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_magnitude_averager
// Accumulates gain-scaled bin magnitudes per FFT bin and returns averages, the peak and the frame count.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  item     | in  | valid/ready   | kind, bin_index, real_part, imag_part
//  result   | out | valid/ready   | average_value, peak_value, frames_seen
//  apb      | in  | psel/penable  | add_gain at byte 0, pready always high
//
//  accumulate: no new beat is accepted until the bin is written; the work
//    is the 32-step square root and the shared 32x32 multiplier (two squares,
//    one gain product)
//  read: two 64-step restoring divisions on one divider, only the peak
//    division for a bin above Nyquist, none while no frame is counted
//  clear and reset: sweep zeroing all WINDOW_SIZE/2+1 words of the sum RAM,
//    no item taken meanwhile
//  a finished read waits in the output register; a stalled result holds the
//    sequencer only when a second result is ready to load
// ----------------------------------------------------------------------------
module spectrum_magnitude_averager
  import sma_pkg::*;
#(
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  sma_stream_if.sink            item,
  sma_stream_if.source          result
);

  localparam int NYQ    = WINDOW_SIZE / 2;
  localparam int DEPTH  = NYQ + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int LOG2W  = $clog2(WINDOW_SIZE + 1) - 1;
  localparam int SH_NYQ = 16 + LOG2W;
  localparam int SH_BIN = SH_NYQ - 1;
  localparam logic [10:0] NYQ_IDX = 11'(NYQ);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_MUL_RE   = 13'b0000000000100,
    S_MUL_IM   = 13'b0000000001000,
    S_SUM      = 13'b0000000010000,
    S_SQRT     = 13'b0000000100000,
    S_MUL_G    = 13'b0000001000000,
    S_ADD      = 13'b0000010000000,
    S_WRITE    = 13'b0000100000000,
    S_RD_FETCH = 13'b0001000000000,
    S_DIV_AVG  = 13'b0010000000000,
    S_DIV_PK   = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_t;

  state_t state;

  // control state
  logic [31:0]       add_gain;
  logic [31:0]       frame_count;
  logic [63:0]       largest_sum;
  logic [AW-1:0]     clr_addr;
  logic              out_valid;

  // datapath registers
  logic [10:0]       bin_q;
  logic              bin_ok;
  logic [31:0]       are;
  logic [31:0]       aim;
  logic [63:0]       prod;
  logic [63:0]       sq_val;
  logic [34:0]       sq_rem;
  logic [31:0]       root;
  logic [STEP_W-1:0] step;
  logic [63:0]       acc_sum;
  logic [63:0]       dv_q;
  logic [31:0]       dv_rem;
  logic [63:0]       avg_q;
  logic [63:0]       pk_q;
  result_t           res_q;

  // ram signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [63:0]       ram_wdata;
  logic              ram_re;
  logic [63:0]       ram_rdata;

  logic              accept;
  logic              cfg_wr;
  logic              load_out;

  // shared multiplier
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_out;

  // square root step
  logic [34:0]       sq_shift;
  logic [34:0]       sq_trial;
  logic              sq_take;

  // divider step
  logic [32:0]       dv_shift;
  logic              dv_take;
  logic [63:0]       dv_q_next;
  logic [31:0]       dv_rem_next;

  // accumulate
  logic [63:0]       add_amt;
  logic [64:0]       sum_wide;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ADD_GAIN) ? add_gain : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      add_gain <= ADD_GAIN_RESET;
    end else if (cfg_wr && paddr[2] == REG_ADD_GAIN) begin
      add_gain <= pwdata;
    end
  end

  // handshakes
  assign item.ready     = (state == S_IDLE);
  assign accept         = item.valid && item.ready;
  assign result.valid   = out_valid;
  assign result.payload = res_q;
  assign load_out       = (state == S_OUT) && (!out_valid || result.ready);

  // multiplier operand select
  always_comb begin
    unique case (state)
      S_MUL_RE: begin
        mul_a = are;
        mul_b = are;
      end
      S_MUL_IM: begin
        mul_a = aim;
        mul_b = aim;
      end
      default: begin
        mul_a = root;
        mul_b = add_gain;
      end
    endcase
  end
  assign mul_out = mul_a * mul_b;

  // one square root digit per cycle
  assign sq_shift = {sq_rem[32:0], sq_val[63:62]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_take  = (sq_shift >= sq_trial);

  // one quotient bit per cycle
  assign dv_shift    = {dv_rem, dv_q[63]};
  assign dv_take     = (dv_shift >= {1'b0, frame_count});
  assign dv_q_next   = {dv_q[62:0], dv_take};
  assign dv_rem_next = dv_take ? 32'(dv_shift - {1'b0, frame_count}) : dv_shift[31:0];

  // scaled magnitude and saturating add
  assign add_amt  = (bin_q == NYQ_IDX) ? (prod >> SH_NYQ) : (prod >> SH_BIN);
  assign sum_wide = {1'b0, ram_rdata} + {1'b0, add_amt};

  // sum storage
  assign ram_re    = accept && (item.payload.bin_index <= NYQ_IDX);
  assign ram_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : bin_q[AW-1:0];
  assign ram_wdata = (state == S_CLEAR) ? 64'd0 : acc_sum;

  sma_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (item.payload.bin_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      frame_count <= '0;
      largest_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (item.payload.kind)
              KIND_ACC: begin
                if (item.payload.bin_index <= NYQ_IDX) begin
                  state <= S_MUL_RE;
                end
              end
              KIND_READ: state <= S_RD_FETCH;
              KIND_CLEAR: begin
                state       <= S_CLEAR;
                clr_addr    <= '0;
                frame_count <= '0;
                largest_sum <= '0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MUL_RE: state <= S_MUL_IM;
        S_MUL_IM: state <= S_SUM;
        S_SUM:    state <= S_SQRT;
        S_SQRT: begin
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            state <= S_MUL_G;
          end
        end
        S_MUL_G: state <= S_ADD;
        S_ADD:   state <= S_WRITE;
        S_WRITE: begin
          if (acc_sum > largest_sum) begin
            largest_sum <= acc_sum;
          end
          if (bin_q == NYQ_IDX && frame_count != 32'hFFFF_FFFF) begin
            frame_count <= frame_count + 32'd1;
          end
          state <= S_IDLE;
        end
        S_RD_FETCH: begin
          if (frame_count == 32'd0) begin
            state <= S_OUT;
          end else if (bin_ok) begin
            state <= S_DIV_AVG;
          end else begin
            state <= S_DIV_PK;
          end
        end
        S_DIV_AVG: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_DIV_PK;
          end
        end
        S_DIV_PK: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          bin_q  <= item.payload.bin_index;
          bin_ok <= (item.payload.bin_index <= NYQ_IDX);
          are    <= item.payload.real_part[31] ? 32'(-item.payload.real_part)
                                               : item.payload.real_part;
          aim    <= item.payload.imag_part[31] ? 32'(-item.payload.imag_part)
                                               : item.payload.imag_part;
        end
      end
      S_MUL_RE: prod <= mul_out;
      S_MUL_IM: begin
        sq_val <= prod;
        prod   <= mul_out;
      end
      S_SUM: begin
        sq_val <= sq_val + prod;
        sq_rem <= '0;
        root   <= '0;
        step   <= '0;
      end
      S_SQRT: begin
        sq_val <= {sq_val[61:0], 2'b00};
        sq_rem <= sq_take ? (sq_shift - sq_trial) : sq_shift;
        root   <= {root[30:0], sq_take};
        step   <= step + 1'b1;
      end
      S_MUL_G: prod <= mul_out;
      S_ADD:   acc_sum <= sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
      S_RD_FETCH: begin
        avg_q  <= '0;
        pk_q   <= '0;
        dv_rem <= '0;
        step   <= '0;
        dv_q   <= bin_ok ? ram_rdata : largest_sum;
      end
      S_DIV_AVG: begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          avg_q  <= dv_q_next;
          dv_q   <= largest_sum;
          dv_rem <= '0;
        end else begin
          dv_q   <= dv_q_next;
          dv_rem <= dv_rem_next;
        end
      end
      S_DIV_PK: begin
        step   <= step + 1'b1;
        dv_q   <= dv_q_next;
        dv_rem <= dv_rem_next;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          pk_q <= dv_q_next;
        end
      end
      S_OUT: begin
        if (load_out) begin
          res_q.average_value <= avg_q;
          res_q.peak_value    <= pk_q;
          res_q.frames_seen   <= frame_count;
        end
      end
      default: ;
    endcase
  end

  // a waiting result is never overwritten by the next read
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !result.ready) |=> (state == S_OUT))
    else $error("result load while previous beat pending");

  // frame counter moves only by one on a write of the Nyquist bin, or back to zero
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && bin_q != NYQ_IDX) |=> (frame_count == $past(frame_count)))
    else $error("frame count changed on an ordinary bin");

  // the peak covers every sum just written
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> (largest_sum >= $past(acc_sum)))
    else $error("peak below a written sum");

  // divided peak never exceeds the peak over the frame count
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && frame_count != 32'd0) |->
      ({32'd0, pk_q} * {64'd0, frame_count} <= {32'd0, largest_sum}))
    else $error("peak quotient too large");

  // reads never start before the sum memory sweep ends
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && clr_addr != AW'(DEPTH - 1)) |=> (state == S_CLEAR))
    else $error("clearing sweep cut short");

endmodule
